// ----- sv/exponential_tap_weight_generator_top_assert.svh -----
// Assertion macros for the exponential tap weight generator.
`ifndef EXPONENTIAL_TAP_WEIGHT_GENERATOR_TOP_ASSERT_SVH
`define EXPONENTIAL_TAP_WEIGHT_GENERATOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ETWG_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ETWG_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ETWG_ASSERT_IMP(label, ante, cons)
`define ETWG_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- sv/etwg_pkg.sv -----
// Shared types and constants of the exponential tap weight generator.
package etwg_pkg;
	localparam int DIV_W = 56;
	localparam int DVS_W = 31;
	localparam int NB_W = 6;
	localparam logic [23:0] LN2_Q24 = 24'd11629080;
	// floor(2^44 / ln2 in Q24), so a reciprocal estimate never overshoots
	localparam logic [20:0] RECIP_LN2_Q44 = 21'd1512775;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [23:0] ONE_Q23 = 24'h80_0000;
	localparam logic [3:0] TAYLOR_TERMS = 4'd12;
	localparam logic [10:0] EXP_ZERO_N = 11'd33;

	typedef struct packed {
		logic            start;
		logic [NB_W-1:0] nbits;
	} div_req_t;
endpackage

// ----- sv/etwg_ram.sv -----
// Generic single-port-write, registered-read RAM.
module etwg_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          waddr,
	input  logic [WIDTH-1:0]       wdata,
	input  logic [AW-1:0]          raddr,
	output logic [WIDTH-1:0]       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- sv/etwg_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
module etwg_div
	import etwg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);
	logic [DIV_W-1:0] acc_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [NB_W-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             fits;
	logic [NB_W-1:0]  align;

	assign trial = {rem_q, acc_q[DIV_W-1]};
	assign fits = trial >= {1'b0, dvs_q};
	assign align = NB_W'(DIV_W) - req.nbits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			rem_q <= '0;
			dvs_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				// align the dividend so its top significant bit leads
				acc_q <= dividend << align;
				rem_q <= '0;
				dvs_q <= divisor;
				cnt_q <= req.nbits;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
				acc_q <= {acc_q[DIV_W-2:0], fits};
				cnt_q <= cnt_q - NB_W'(1);
				if (cnt_q == NB_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quotient = acc_q;
endmodule

// ----- sv/etwg_sqrt.sv -----
// Bit-pair square root with round to nearest and saturation to 16 bits.
module etwg_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] q,
	output logic        done,
	output logic [15:0] weight
);
	logic [33:0] v_q;
	logic [33:0] res_q;
	logic [33:0] bit_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] sum;
	logic [33:0] res_rnd;

	assign sum = res_q + bit_q;
	assign res_rnd = (v_q > res_q) ? res_q + 34'd1 : res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			res_q <= '0;
			bit_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				v_q <= {1'b0, q};
				res_q <= '0;
				bit_q <= 34'h1_0000_0000;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (v_q >= sum) begin
					v_q <= v_q - sum;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q == 34'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign weight = (res_rnd > 34'd65535) ? 16'hFFFF : res_rnd[15:0];
endmodule

// ----- sv/exponential_tap_weight_generator_top.sv -----
// Top level of the exponential tap weight generator.
// A request of N taps first fills the power store, one power per tap (no divides when tau is zero),
// then computes each weight with a 56-bit divide and a 17-step square root.
// A zero tap count gives its error result in the cycle after acceptance.
// One request at a time; the shared bit-serial divider dominates the time per request.
// Reset (arst_n low, asynchronous) clears the sequencer, sum, count and output valid.
`include "exponential_tap_weight_generator_top_assert.svh"
module exponential_tap_weight_generator_top
	import etwg_pkg::*;
#(
	parameter int MAX_TAPS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // path_index[7:0], tap_count[14:8], start_tap[24:15], tau_samples[40:25]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // path_echo[7:0], tap_address[18:8], weight[34:19]
	output logic        m_tlast,
	output logic        m_tuser   // error_flag[0]
);
	localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_X, ST_XW, ST_NW, ST_NR, ST_NC, ST_MUL, ST_KD, ST_KW, ST_PC,
		ST_WR, ST_RD, ST_RW, ST_QW, ST_SW, ST_OUT
	} state_t;

	state_t       state_q;
	logic [7:0]   path_q;
	logic [6:0]   cnt_q;
	logic [9:0]   start_q;
	logic [15:0]  tau_q;
	logic [AW-1:0] idx_q;
	logic [30:0]  sum_q;
	logic [33:0]  x_q;
	logic [10:0]  n_q;
	logic [23:0]  r_q;
	logic [30:0]  t_q;
	logic signed [31:0] s_q;
	logic [3:0]   k_q;
	logic [53:0]  prod_q;
	logic [23:0]  p_q;
	logic [7:0]   o_path_q;
	logic [10:0]  o_addr_q;
	logic [15:0]  o_weight_q;
	logic         o_last_q;
	logic         o_err_q;
	logic         o_valid_q;

	div_req_t         dreq;
	logic [DIV_W-1:0] d_dividend;
	logic [DVS_W-1:0] d_divisor;
	logic             d_done;
	logic [DIV_W-1:0] d_quot;
	logic             sq_start;
	logic [32:0]      sq_q;
	logic             sq_done;
	logic [15:0]      sq_weight;
	logic [23:0]      ram_rdata;
	logic             ram_we;

	logic [6:0]   in_count;
	logic         is_last;
	logic [5:0]   shamt;
	logic [39:0]  e_rnd;
	logic [23:0]  p_calc;
	logic [30:0]  t_next;

	assign in_count = s_tdata[14:8];
	assign is_last = (7'(idx_q) + 7'd1) == cnt_q;
	assign t_next = {1'b0, d_quot[29:0]};

	// round the Q30 exponential down by 2^(7+n)
	always_comb begin
		shamt = 6'd7 + n_q[5:0];
		e_rnd = (s_q[31] ? 40'd0 : 40'($unsigned(s_q))) + (40'd1 << (shamt - 6'd1));
		p_calc = (n_q >= EXP_ZERO_N) ? 24'd0 : 24'(e_rnd >> shamt);
	end

	always_comb begin
		dreq.start = 1'b0;
		dreq.nbits = NB_W'(34);
		d_dividend = 56'(x_q);
		d_divisor = 31'(LN2_Q24);
		case (state_q)
			ST_X: begin
				dreq.start = tau_q != 16'd0;
				d_dividend = 56'(idx_q) << 28;
				d_divisor = 31'(tau_q);
			end
			ST_KD: begin
				dreq.start = 1'b1;
				dreq.nbits = NB_W'(30);
				d_dividend = 56'(prod_q[53:24]);
				d_divisor = 31'(k_q);
			end
			ST_RW: begin
				dreq.start = 1'b1;
				dreq.nbits = NB_W'(56);
				d_dividend = {ram_rdata, 32'd0};
				d_divisor = sum_q;
			end
			default: begin
			end
		endcase
	end

	assign sq_start = (state_q == ST_QW) && d_done;
	assign sq_q = (sum_q == 31'd0) ? 33'd0 : d_quot[32:0];
	assign ram_we = state_q == ST_WR;

	etwg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (dreq),
		.dividend  (d_dividend),
		.divisor   (d_divisor),
		.done      (d_done),
		.quotient  (d_quot)
	);

	etwg_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.q      (sq_q),
		.done   (sq_done),
		.weight (sq_weight)
	);

	etwg_ram #(.WIDTH(24), .DEPTH(MAX_TAPS)) u_power_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (p_q),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			path_q <= '0;
			cnt_q <= '0;
			start_q <= '0;
			tau_q <= '0;
			idx_q <= '0;
			sum_q <= '0;
			x_q <= '0;
			n_q <= '0;
			r_q <= '0;
			t_q <= '0;
			s_q <= '0;
			k_q <= '0;
			prod_q <= '0;
			p_q <= '0;
			o_path_q <= '0;
			o_addr_q <= '0;
			o_weight_q <= '0;
			o_last_q <= 1'b0;
			o_err_q <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						path_q <= s_tdata[7:0];
						start_q <= s_tdata[24:15];
						tau_q <= s_tdata[40:25];
						idx_q <= '0;
						sum_q <= '0;
						if (in_count == 7'd0) begin
							cnt_q <= '0;
							o_path_q <= s_tdata[7:0];
							o_addr_q <= {1'b0, s_tdata[24:15]};
							o_weight_q <= '0;
							o_last_q <= 1'b1;
							o_err_q <= 1'b1;
							o_valid_q <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							cnt_q <= (in_count > 7'(MAX_TAPS)) ? 7'(MAX_TAPS) : in_count;
							state_q <= ST_X;
						end
					end
				end
				ST_X: begin
					if (tau_q == 16'd0) begin
						p_q <= (idx_q == '0) ? ONE_Q23 : 24'd0;
						state_q <= ST_WR;
					end else begin
						state_q <= ST_XW;
					end
				end
				ST_XW: begin
					if (d_done) begin
						x_q <= d_quot[33:0];
						state_q <= ST_NW;
					end
				end
				ST_NW: begin
					// estimate n = x / ln2 by reciprocal; it falls short by at most one
					n_q <= 11'((45'(x_q[33:10]) * 45'(RECIP_LN2_Q44)) >> 34);
					state_q <= ST_NR;
				end
				ST_NR: begin
					x_q <= x_q - 34'(35'(n_q) * 35'(LN2_Q24));
					state_q <= ST_NC;
				end
				ST_NC: begin
					if (x_q >= 34'(LN2_Q24)) begin
						x_q <= x_q - 34'(LN2_Q24);
						n_q <= n_q + 11'd1;
					end else begin
						r_q <= x_q[23:0];
						t_q <= ONE_Q30;
						s_q <= 32'(ONE_Q30);
						k_q <= 4'd1;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q <= 54'(t_q) * 54'(r_q);
					state_q <= ST_KD;
				end
				ST_KD: begin
					state_q <= ST_KW;
				end
				ST_KW: begin
					if (d_done) begin
						t_q <= t_next;
						// odd terms subtract, even terms add
						s_q <= k_q[0] ? s_q - $signed({1'b0, t_next})
						              : s_q + $signed({1'b0, t_next});
						if (k_q == TAYLOR_TERMS) begin
							state_q <= ST_PC;
						end else begin
							k_q <= k_q + 4'd1;
							state_q <= ST_MUL;
						end
					end
				end
				ST_PC: begin
					p_q <= p_calc;
					state_q <= ST_WR;
				end
				ST_WR: begin
					sum_q <= sum_q + 31'(p_q);
					if (is_last) begin
						idx_q <= '0;
						state_q <= ST_RD;
					end else begin
						idx_q <= idx_q + AW'(1);
						state_q <= ST_X;
					end
				end
				ST_RD: begin
					state_q <= ST_RW;
				end
				ST_RW: begin
					state_q <= ST_QW;
				end
				ST_QW: begin
					if (d_done) begin
						state_q <= ST_SW;
					end
				end
				ST_SW: begin
					if (sq_done) begin
						o_path_q <= path_q;
						o_addr_q <= {1'b0, start_q} + 11'(idx_q);
						o_weight_q <= sq_weight;
						o_last_q <= is_last;
						o_err_q <= 1'b0;
						o_valid_q <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						o_valid_q <= 1'b0;
						if (o_last_q) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + AW'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = o_valid_q;
	assign m_tdata = {5'd0, o_weight_q, o_addr_q, o_path_q};
	assign m_tlast = o_last_q;
	assign m_tuser = o_err_q;

	`ETWG_ASSERT_IMP(a_one_item, m_tvalid, !s_tready)
	`ETWG_ASSERT_NXT(a_err_next, s_tvalid && s_tready && (s_tdata[14:8] == 7'd0), m_tvalid && m_tuser && m_tlast)
	`ETWG_ASSERT_IMP(a_wr_range, ram_we, 7'(idx_q) < cnt_q)
endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the exponential tap weight generator top level.
module tb;
	import etwg_pkg::*;

	localparam int TAPS_MAX = 64;
	localparam logic [23:0] LN2 = 24'd11629080;

	typedef struct {
		logic [7:0]  path;
		logic [10:0] addr;
		logic [15:0] weight;
		logic        last;
		logic        err;
	} weight_t;

	typedef struct {
		logic [7:0]  path;
		logic [6:0]  count;
		logic [9:0]  start;
		logic [15:0] tau;
		logic        has_exp;
		logic [15:0] exp_w0;
	} req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	weight_t expected_weights[$];
	int      n_errors = 0;
	int      n_weights = 0;
	int      n_requests = 0;
	bit      hold_off = 1'b0;
	bit      stim_done = 1'b0;

	exponential_tap_weight_generator_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// exp(-i/tau) in Q1.23
	function automatic logic [23:0] tap_power(input int unsigned i, input logic [15:0] tau);
		logic [63:0] x, n, r, t;
		longint s;
		int sh;
		if (tau == 0) return (i == 0) ? 24'h80_0000 : 24'd0;
		x = (64'(i) << 28) / 64'(tau);
		n = x / LN2;
		r = x - n * LN2;
		t = 64'd1 << 30;
		s = longint'(t);
		for (int k = 1; k <= 12; k++) begin
			t = ((t * r) >> 24) / k;
			if (k % 2) s -= longint'(t);
			else s += longint'(t);
		end
		if (s < 0) s = 0;
		if (n >= 33) return 24'd0;
		sh = 7 + int'(n);
		return 24'((64'(s) + (64'd1 << (sh - 1))) >> sh);
	endfunction

	function automatic logic [15:0] rounded_sqrt(input logic [63:0] q);
		logic [63:0] res, b, v;
		res = 0;
		b = 64'd1 << 62;
		v = q;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		if (v > res) res++;
		return (res > 65535) ? 16'hFFFF : res[15:0];
	endfunction

	task automatic predict_weights(input req_t rq);
		logic [23:0] pw[TAPS_MAX];
		logic [30:0] total;
		int unsigned cnt;
		logic [63:0] q;
		weight_t w;
		if (rq.count == 0) begin
			w = '{rq.path, {1'b0, rq.start}, 16'd0, 1'b1, 1'b1};
			expected_weights.push_back(w);
			return;
		end
		cnt = (rq.count > TAPS_MAX) ? TAPS_MAX : rq.count;
		total = '0;
		for (int i = 0; i < cnt; i++) begin
			pw[i] = tap_power(i, rq.tau);
			total = total + 31'(pw[i]);
		end
		for (int i = 0; i < cnt; i++) begin
			q = (total != 0) ? ((64'(pw[i]) << 32) / 64'(total)) : 64'd0;
			w = '{rq.path, 11'({1'b0, rq.start} + 11'(i)), rounded_sqrt(q),
				i + 1 == cnt, 1'b0};
			expected_weights.push_back(w);
		end
	endtask

	task automatic idle_gap(input int lo_pct);
		int n;
		n = ($urandom_range(0, 99) < lo_pct) ? $urandom_range(10, 60) : $urandom_range(1, 3);
		repeat (n) @(negedge clk);
	endtask

	task automatic send_request(input req_t rq);
		predict_weights(rq);
		if (rq.has_exp && expected_weights.size() > 0)
			expected_weights[expected_weights.size() - ((rq.count == 0) ? 1 :
				((rq.count > TAPS_MAX) ? TAPS_MAX : rq.count))].weight = rq.exp_w0;
		s_tdata <= {7'd0, rq.tau, rq.start, rq.count, rq.path};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		n_requests++;
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// Sender
	initial begin
		req_t directed[$];
		req_t rq;
		directed = '{
			'{8'd0,   7'd0,  10'd0,    16'd16,    1, 16'd0},
			'{8'd255, 7'd0,  10'd1023, 16'hFFFF,  1, 16'd0},
			'{8'd1,   7'd1,  10'd5,    16'd16,    1, 16'hFFFF},
			'{8'd2,   7'd4,  10'd10,   16'd0,     1, 16'hFFFF},
			'{8'd3,   7'd64, 10'd1023, 16'd0,     1, 16'hFFFF},
			'{8'd4,   7'd127,10'd1000, 16'd160,   0, 16'd0},
			'{8'd5,   7'd65, 10'd0,    16'hFFFF,  0, 16'd0},
			'{8'd6,   7'd8,  10'd512,  16'd1,     0, 16'd0},
			'{8'd7,   7'd16, 10'd300,  16'd40,    0, 16'd0},
			'{8'h55,  7'd3,  10'h2AA,  16'h5555,  0, 16'd0},
			'{8'hAA,  7'd5,  10'h155,  16'hAAAA,  0, 16'd0},
			'{8'd9,   7'd2,  10'd7,    16'd8,     0, 16'd0}
		};
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (directed[k]) begin
			send_request(directed[k]);
			idle_gap(10);
		end
		for (int k = 0; k < 128; k++) begin
			rq.path = 8'($urandom);
			case ($urandom_range(0, 9))
				0: rq.count = 7'd0;
				1: rq.count = 7'($urandom_range(65, 127));
				2: rq.count = 7'($urandom_range(17, 64));
				default: rq.count = 7'($urandom_range(1, 16));
			endcase
			rq.start = 10'($urandom);
			rq.tau = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
			rq.has_exp = 0;
			rq.exp_w0 = 0;
			if (k == 40) begin
				// let the pipeline drain completely before resuming
				wait (expected_weights.size() == 0);
				@(negedge clk);
			end
			if (k == 80) hold_off = 1'b1;
			send_request(rq);
			idle_gap(8);
		end
		stim_done = 1'b1;
	end

	// Receiver
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (3000) @(negedge clk);
				hold_off = 1'b0;
			end
			n = ($urandom_range(0, 99) < 5) ? $urandom_range(10, 80) :
				(($urandom_range(0, 99) < 30) ? 1 : 0);
			if (n == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	// Checker
	always @(posedge clk) begin
		weight_t w;
		if (arst_n && m_tvalid && m_tready) begin
			n_weights++;
			if (expected_weights.size() == 0) begin
				$display("%0t: unexpected transaction, actual %h last %b err %b",
					$time, m_tdata, m_tlast, m_tuser);
				n_errors++;
			end else begin
				w = expected_weights.pop_front();
				if (m_tdata[7:0] !== w.path || m_tdata[18:8] !== w.addr ||
				    m_tdata[34:19] !== w.weight || m_tdata[39:35] !== 5'd0 ||
				    m_tlast !== w.last || m_tuser !== w.err) begin
					$display("%0t: mismatch, expected path %0d addr %0d weight %0d last %b err %b",
						$time, w.path, w.addr, w.weight, w.last, w.err);
					$display("%0t:           actual   path %0d addr %0d weight %0d last %b err %b",
						$time, m_tdata[7:0], m_tdata[18:8], m_tdata[34:19], m_tlast, m_tuser);
					n_errors++;
				end
			end
		end
	end

	initial begin
		wait (stim_done);
		wait (expected_weights.size() == 0);
		repeat (200) @(posedge clk);
		$display("Covered %0d requests (zero, saturated and full counts, zero and extreme tau)",
			n_requests);
		$display("and checked %0d weight transactions under random stalls on both sides.",
			n_weights);
		if (n_errors == 0 && expected_weights.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#300000000;
		$display("timeout with %0d transactions outstanding", expected_weights.size());
		$display("status: fail");
		$finish;
	end
endmodule

// ----- exponential_tap_weight_generator_top.f -----
+incdir+sv
sv/etwg_pkg.sv
sv/etwg_ram.sv
sv/etwg_div.sv
sv/etwg_sqrt.sv
sv/exponential_tap_weight_generator_top.sv
verif/tb.sv
